>>> hdl/spq_pkg.sv
`default_nettype none
package spq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int PRI_W = 8;
    localparam int ID_W  = 16;
    localparam int OCC_W = 5;

    typedef logic [PRI_W-1:0] t_pri;
    typedef logic [ID_W-1:0]  t_id;
    typedef logic [OCC_W-1:0] t_occ;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_REMOVE = 1'b1
    } t_mode;

endpackage
`default_nettype wire

>>> hdl/stable_priority_queue_unit.sv
`default_nettype none
// Sorted priority queue of QUEUE_DEPTH entries held in a row of slot registers,
// slot 0 being the head. One word (insert or removal) is taken every clock:
// o_busy stays low. The word is registered, then every slot compares its
// priority with the request in parallel and shifts or loads in a single pass,
// and the result passes through the result register to the output ports, marked
// by o_strobe for exactly one cycle. The receiver cannot stall: each result
// must be taken in the cycle it is shown. Equal priorities leave in arrival
// order; inserts into a full queue and removals from an empty one only report
// a status.
module stable_priority_queue_unit #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic               i_mode,
    input  wire spq_pkg::t_pri      i_priority_req,
    input  wire spq_pkg::t_id       i_patient_id,
    output logic                    o_strobe,
    output logic [1:0]              o_status,
    output spq_pkg::t_id            o_out_id,
    output spq_pkg::t_pri           o_out_priority,
    output spq_pkg::t_occ           o_occupancy
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // input register
    logic   r_in_vld;
    t_mode  r_mode;
    t_pri   r_pri;
    t_id    r_pid;

    // slot row, valid bits form a thermometer from slot 0
    t_pri                   r_slot_pri [QUEUE_DEPTH];
    t_id                    r_slot_id  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] r_valid;
    logic [CNT_W-1:0]       r_count;

    t_pri                   n_slot_pri [QUEUE_DEPTH];
    t_id                    n_slot_id  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] n_valid;
    logic [CNT_W-1:0]       n_count;

    // result register
    logic    r_strobe;
    t_status r_status;
    t_id     r_out_id;
    t_pri    r_out_pri;

    t_status n_status;
    t_id     n_out_id;
    t_pri    n_out_pri;

    // slot is behind the insert point: empty or strictly greater priority
    logic [QUEUE_DEPTH-1:0] w_behind;
    logic                   w_full;
    logic                   w_empty;
    logic                   w_do_ins;
    logic                   w_do_rem;

    assign w_full   = r_valid[QUEUE_DEPTH-1];
    assign w_empty  = !r_valid[0];
    assign w_do_ins = r_in_vld && (r_mode == MODE_INSERT) && !w_full;
    assign w_do_rem = r_in_vld && (r_mode == MODE_REMOVE) && !w_empty;

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_behind[i] = !r_valid[i] || (r_slot_pri[i] > r_pri);
        end
    end

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_slot_pri[i] = r_slot_pri[i];
            n_slot_id[i]  = r_slot_id[i];
            n_valid[i]    = r_valid[i];
            if (w_do_ins) begin
                if (i == 0) begin
                    n_valid[i] = 1'b1;
                    if (w_behind[i]) begin
                        n_slot_pri[i] = r_pri;
                        n_slot_id[i]  = r_pid;
                    end
                end else begin
                    n_valid[i] = r_valid[i] || r_valid[i-1];
                    if (w_behind[i] && !w_behind[i-1]) begin
                        n_slot_pri[i] = r_pri;
                        n_slot_id[i]  = r_pid;
                    end else if (w_behind[i]) begin
                        n_slot_pri[i] = r_slot_pri[i-1];
                        n_slot_id[i]  = r_slot_id[i-1];
                    end
                end
            end else if (w_do_rem) begin
                if (i == QUEUE_DEPTH - 1) begin
                    n_valid[i] = 1'b0;
                end else begin
                    n_valid[i]    = r_valid[i+1];
                    n_slot_pri[i] = r_slot_pri[i+1];
                    n_slot_id[i]  = r_slot_id[i+1];
                end
            end
        end
    end

    always_comb begin
        n_count   = r_count;
        n_out_id  = '0;
        n_out_pri = '0;
        n_status  = ST_INSERTED;
        if (r_mode == MODE_INSERT) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_status  = ST_REMOVED;
                n_out_id  = r_slot_id[0];
                n_out_pri = r_slot_pri[0];
                n_count   = r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_strobe <= 1'b0;
            r_valid  <= '0;
            r_count  <= '0;
        end else begin
            r_in_vld <= i_start;
            r_strobe <= r_in_vld;
            r_valid  <= n_valid;
            if (r_in_vld) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= t_mode'(i_mode);
        r_pri  <= i_priority_req;
        r_pid  <= i_patient_id;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_slot_pri[i] <= n_slot_pri[i];
            r_slot_id[i]  <= n_slot_id[i];
        end
        if (r_in_vld) begin
            r_status  <= n_status;
            r_out_id  <= n_out_id;
            r_out_pri <= n_out_pri;
        end
    end

    assign o_busy         = 1'b0;
    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_out_id       = r_out_id;
    assign o_out_priority = r_out_pri;
    assign o_occupancy    = OCC_W'(r_count);

    // checks
    a_strobe_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld |=> o_strobe)
        else $error("result strobe missing");

    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == r_count)
        else $error("entry count out of step with valid bits");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_mode == MODE_INSERT && !w_full) |=>
            (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not add an entry");

    a_empty_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == ST_EMPTY || o_status == ST_FULL)) |->
            (o_out_id == '0 && o_out_priority == '0))
        else $error("non-removal result carries data");

endmodule
`default_nettype wire
